[design/conv3x3_line_buffer_filter_unit_macros.svh]
// ------------------------------------------------------------------------
// conv3x3 line buffer filter assertion macros
// shared concurrent assertion forms for the checker
// ------------------------------------------------------------------------
`ifndef CONV3X3_LINE_BUFFER_FILTER_UNIT_MACROS_SVH
`define CONV3X3_LINE_BUFFER_FILTER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define C3X3_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define C3X3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/c3x3lbf_pkg.sv]
// ------------------------------------------------------------------------
// c3x3lbf_pkg
// shared types and constants of the 3x3 line buffer filter
// ------------------------------------------------------------------------
package c3x3lbf_pkg;

    localparam int KSIZE      = 3;
    localparam int COEF_BITS  = 16;
    localparam int COEF_ROW_W = KSIZE * COEF_BITS;
    localparam int ROWS_BITS  = 16;
    localparam int COLS_BITS  = 11;
    localparam int OUT_BITS   = 36;

    localparam int ADDR_BITS  = 6;
    localparam int DATA_BITS  = 64;
    localparam int REG_SHIFT  = 3;
    localparam int REG_IDX_W  = ADDR_BITS - REG_SHIFT;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CNT_W = FIFO_AW + 1;

    typedef logic [COEF_ROW_W-1:0] coef_row_t;
    typedef logic [REG_IDX_W-1:0]  reg_idx_t;

    localparam reg_idx_t REG_COEF_ROW_0 = 3'd0;
    localparam reg_idx_t REG_COEF_ROW_1 = 3'd1;
    localparam reg_idx_t REG_COEF_ROW_2 = 3'd2;
    localparam reg_idx_t REG_FRAME_ROWS = 3'd3;
    localparam reg_idx_t REG_FRAME_COLS = 3'd4;

    localparam logic [ROWS_BITS-1:0] ROWS_RESET = 16'd1024;
    localparam logic [COLS_BITS-1:0] COLS_RESET = 11'd1024;

endpackage

[design/c3x3lbf_ram.sv]
// ------------------------------------------------------------------------
// c3x3lbf_ram
// simple dual-port ram, one write port, one registered read port
// ------------------------------------------------------------------------
module c3x3lbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/conv3x3_line_buffer_filter_unit.sv]
// ------------------------------------------------------------------------
// conv3x3_line_buffer_filter_unit
// streaming 3x3 valid-mode convolution over a raster pixel stream
// ------------------------------------------------------------------------
// pixels enter one beat at a time on pixel_valid/pixel_ready in raster
// order; a result beat (filtered, frame_end) leaves on result_valid/
// result_ready for every pixel whose row and column are both at least 2.
// the two previous rows sit packed in one line ram, read at the pixel's
// column and written back in the next cycle, with forwarding when the
// next pixel hits the same column (single-column frames).
// one pixel is accepted per cycle while pixel_ready is high; a result
// passes ram read, multiply, row sums and final sum into an 8-beat output
// queue. pixel_ready stays high while the queue plus in-flight results
// leave room, so a stalled receiver stops input only once the queue fills.
// coefficients and frame size are written over the apb port at 8*index
// while the block is idle. reset clears positions, pipeline and queue and
// loads the register reset values; the line ram needs no clearing.
// ------------------------------------------------------------------------
module conv3x3_line_buffer_filter_unit #(
    parameter int MAX_COLS   = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [c3x3lbf_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [c3x3lbf_pkg::DATA_BITS-1:0]      pwdata,
    output logic [c3x3lbf_pkg::DATA_BITS-1:0]      prdata,
    output logic                                   pready,

    input  logic                                   pixel_valid,
    output logic                                   pixel_ready,
    input  logic signed [PIXEL_BITS-1:0]           pixel,

    output logic                                   result_valid,
    input  logic                                   result_ready,
    output logic signed [c3x3lbf_pkg::OUT_BITS-1:0] filtered,
    output logic                                   frame_end
);

    import c3x3lbf_pkg::*;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int LINE_W = 2 * PIXEL_BITS;
    localparam int PROD_W = PIXEL_BITS + COEF_BITS;
    localparam int SUM_W  = (PROD_W + 4 > OUT_BITS) ? PROD_W + 4 : OUT_BITS;
    localparam int WIN_N  = 2 * KSIZE;

    // configuration registers
    coef_row_t              coef_reg [KSIZE];
    logic [ROWS_BITS-1:0]   frame_rows_reg;
    logic [COLS_BITS-1:0]   frame_cols_reg;
    reg_idx_t               wr_idx;
    reg_idx_t               rd_idx;
    logic                   cfg_we;

    // position and stage 0
    logic [COL_W-1:0]       col_pos_reg, col_pos_next;
    logic [ROWS_BITS-1:0]   row_pos_reg, row_pos_next;
    logic [COL_W-1:0]       last_col_idx;
    logic [ROWS_BITS-1:0]   last_row_idx;
    logic [COL_W-1:0]       col_cur;
    logic                   is_last_col;
    logic                   is_last_row;
    logic                   has_result;
    logic                   accept;
    logic                   fwd_hit;

    // stage 1
    logic                   s1_valid_reg;
    logic                   s1_res_reg;
    logic                   s1_end_reg;
    logic [COL_W-1:0]       s1_col_reg;
    logic signed [PIXEL_BITS-1:0] s1_px_reg;
    logic                   s1_fwd_reg;
    logic [LINE_W-1:0]      s1_fwd_data_reg;
    logic [LINE_W-1:0]      ram_rdata;
    logic [LINE_W-1:0]      line_data;
    logic [LINE_W-1:0]      line_wdata;
    logic signed [PIXEL_BITS-1:0] p1;
    logic signed [PIXEL_BITS-1:0] p2;
    logic signed [PIXEL_BITS-1:0] win_reg [WIN_N];
    logic signed [PIXEL_BITS-1:0] tap [KSIZE][KSIZE];
    logic signed [COEF_BITS-1:0]  coef_sel [KSIZE][KSIZE];
    logic signed [PROD_W-1:0]     prod_next [KSIZE][KSIZE];

    // stage 2 and 3
    logic                   s2_valid_reg;
    logic                   s2_end_reg;
    logic signed [PROD_W-1:0] prod_reg [KSIZE][KSIZE];
    logic signed [SUM_W-1:0]  row_sum_next [KSIZE];
    logic                   s3_valid_reg;
    logic                   s3_end_reg;
    logic signed [SUM_W-1:0]  row_sum_reg [KSIZE];
    logic signed [SUM_W-1:0]  total;

    // output queue
    logic [OUT_BITS-1:0]    fifo_data_reg [FIFO_DEPTH];
    logic                   fifo_end_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     wr_ptr_reg;
    logic [FIFO_AW-1:0]     rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]  count_reg, count_next;
    logic [FIFO_CNT_W:0]    credit_used;
    logic                   push;
    logic                   pop;

    // apb register file
    assign pready = 1'b1;
    assign wr_idx = paddr[ADDR_BITS-1:REG_SHIFT];
    assign rd_idx = paddr[ADDR_BITS-1:REG_SHIFT];
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KSIZE; i++)
            begin
                coef_reg[i] <= '0;
            end
            frame_rows_reg <= ROWS_RESET;
            frame_cols_reg <= COLS_RESET;
        end
        else if (cfg_we)
        begin
            case (wr_idx)
                REG_COEF_ROW_0: coef_reg[0] <= pwdata[COEF_ROW_W-1:0];
                REG_COEF_ROW_1: coef_reg[1] <= pwdata[COEF_ROW_W-1:0];
                REG_COEF_ROW_2: coef_reg[2] <= pwdata[COEF_ROW_W-1:0];
                REG_FRAME_ROWS: frame_rows_reg <= pwdata[ROWS_BITS-1:0];
                REG_FRAME_COLS: frame_cols_reg <= pwdata[COLS_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (rd_idx)
            REG_COEF_ROW_0: prdata = DATA_BITS'(coef_reg[0]);
            REG_COEF_ROW_1: prdata = DATA_BITS'(coef_reg[1]);
            REG_COEF_ROW_2: prdata = DATA_BITS'(coef_reg[2]);
            REG_FRAME_ROWS: prdata = DATA_BITS'(frame_rows_reg);
            REG_FRAME_COLS: prdata = DATA_BITS'(frame_cols_reg);
            default:        prdata = '0;
        endcase
    end

    // stage 0: position, ram read, forwarding check
    always_comb
    begin
        if (frame_cols_reg == '0)
        begin
            last_col_idx = '0;
        end
        else if (32'(frame_cols_reg) > 32'(MAX_COLS))
        begin
            last_col_idx = COL_W'(MAX_COLS - 1);
        end
        else
        begin
            last_col_idx = COL_W'(frame_cols_reg - COLS_BITS'(1));
        end

        if (frame_rows_reg == '0)
        begin
            last_row_idx = '0;
        end
        else
        begin
            last_row_idx = frame_rows_reg - ROWS_BITS'(1);
        end

        col_cur     = (col_pos_reg >= last_col_idx) ? last_col_idx : col_pos_reg;
        is_last_col = (col_cur == last_col_idx);
        is_last_row = (row_pos_reg >= last_row_idx);
        has_result  = (row_pos_reg >= ROWS_BITS'(KSIZE - 1))
                   && (col_cur >= COL_W'(KSIZE - 1));

        if (is_last_col)
        begin
            col_pos_next = '0;
            row_pos_next = is_last_row ? '0 : row_pos_reg + ROWS_BITS'(1);
        end
        else
        begin
            col_pos_next = col_cur + COL_W'(1);
            row_pos_next = row_pos_reg;
        end
    end

    assign credit_used = (FIFO_CNT_W + 1)'(count_reg)
                       + (FIFO_CNT_W + 1)'(s1_valid_reg && s1_res_reg)
                       + (FIFO_CNT_W + 1)'(s2_valid_reg)
                       + (FIFO_CNT_W + 1)'(s3_valid_reg);
    assign pixel_ready = (credit_used < (FIFO_CNT_W + 1)'(FIFO_DEPTH));
    assign accept      = pixel_valid && pixel_ready;
    assign fwd_hit     = s1_valid_reg && (s1_col_reg == col_cur);

    c3x3lbf_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_COLS),
        .AW    (COL_W)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (line_wdata),
        .re    (accept),
        .raddr (col_cur),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_pos_reg <= col_pos_next;
                row_pos_reg <= row_pos_next;
            end
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg && s1_res_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg       <= pixel;
            s1_col_reg      <= col_cur;
            s1_res_reg      <= has_result;
            s1_end_reg      <= is_last_col && is_last_row;
            s1_fwd_reg      <= fwd_hit;
            s1_fwd_data_reg <= line_wdata;
        end
    end

    // stage 1: line read-modify-write, window shift, products
    assign line_data  = s1_fwd_reg ? s1_fwd_data_reg : ram_rdata;
    assign p1         = line_data[PIXEL_BITS-1:0];
    assign p2         = line_data[LINE_W-1:PIXEL_BITS];
    assign line_wdata = {p1, s1_px_reg};

    always_comb
    begin
        for (int a = 0; a < KSIZE; a++)
        begin
            tap[a][0] = win_reg[a];
            tap[a][1] = win_reg[KSIZE + a];
        end
        tap[0][2] = s1_px_reg;
        tap[1][2] = p1;
        tap[2][2] = p2;

        for (int a = 0; a < KSIZE; a++)
        begin
            for (int b = 0; b < KSIZE; b++)
            begin
                coef_sel[a][b]  = coef_reg[a][b*COEF_BITS +: COEF_BITS];
                prod_next[a][b] = coef_sel[a][b] * tap[a][b];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            for (int a = 0; a < KSIZE; a++)
            begin
                win_reg[a] <= win_reg[KSIZE + a];
            end
            win_reg[KSIZE]     <= s1_px_reg;
            win_reg[KSIZE + 1] <= p1;
            win_reg[KSIZE + 2] <= p2;
        end
        prod_reg   <= prod_next;
        s2_end_reg <= s1_end_reg;
    end

    // stage 2: row sums
    always_comb
    begin
        for (int a = 0; a < KSIZE; a++)
        begin
            row_sum_next[a] = SUM_W'(prod_reg[a][0]) + SUM_W'(prod_reg[a][1])
                            + SUM_W'(prod_reg[a][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        row_sum_reg <= row_sum_next;
        s3_end_reg  <= s2_end_reg;
    end

    // stage 3: final sum into the output queue
    assign total = row_sum_reg[0] + row_sum_reg[1] + row_sum_reg[2];
    assign push  = s3_valid_reg;
    assign pop   = result_valid && result_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_data_reg[wr_ptr_reg] <= total[OUT_BITS-1:0];
            fifo_end_reg[wr_ptr_reg]  <= s3_end_reg;
        end
    end

    assign result_valid = (count_reg != '0);
    assign filtered     = fifo_data_reg[rd_ptr_reg];
    assign frame_end    = fifo_end_reg[rd_ptr_reg];

endmodule

[design/c3x3lbf_checker.sv]
// ------------------------------------------------------------------------
// c3x3lbf_checker
// port-level checks of the 3x3 line buffer filter, bound to the top level
// ------------------------------------------------------------------------
`include "conv3x3_line_buffer_filter_unit_macros.svh"

module c3x3lbf_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   pixel_valid,
    input  logic                                   pixel_ready,
    input  logic                                   result_valid,
    input  logic                                   result_ready,
    input  logic signed [c3x3lbf_pkg::OUT_BITS-1:0] filtered,
    input  logic                                   frame_end
);

    import c3x3lbf_pkg::*;

    logic [OUT_BITS:0] out_beat;

    assign out_beat = {frame_end, filtered};

    // a stalled result beat holds
    `C3X3_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(out_beat), "result beat dropped or changed while stalled")

    // with nothing queued, input is never throttled
    `C3X3_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !result_valid, pixel_ready, "pixel_ready low with empty output queue")

    // a result surfacing from an empty queue came from an accepted pixel beat
    `C3X3_ASSERT_NOW(a_result_latency, clk, rst_n, $rose(result_valid), $past(pixel_valid && pixel_ready, 4), "result appeared without matching pixel beat")

endmodule

bind conv3x3_line_buffer_filter_unit c3x3lbf_checker u_c3x3lbf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .filtered     (filtered),
    .frame_end    (frame_end)
);

[verif/conv3x3_line_buffer_filter_unit_tb.sv]
// ------------------------------------------------------------------------
// conv3x3_line_buffer_filter_unit_tb
// self-checking bench for the streaming 3x3 valid-mode convolution
// ------------------------------------------------------------------------
// a short stimulus table covers reset coefficients, extreme pixels and
// coefficients and degenerate frame sizes; dedicated frames then cover
// row and column clamping, mid-frame resizing, a long output stall and
// sender drains; random frames with random kernels close the run. every
// accepted pixel steps a shadow of the line stores and the window, and
// each result beat is compared with the oldest pending sum.
// ------------------------------------------------------------------------
module conv3x3_line_buffer_filter_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import c3x3lbf_pkg::*;

    localparam int MAX_COLS      = 1024;
    localparam int PIXEL_BITS    = 16;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int RAND_ITEMS    = 380;
    localparam int CYCLE_LIMIT   = 2_000_000;

    typedef logic signed [PIXEL_BITS-1:0] px_t;

    typedef struct {
        logic signed [OUT_BITS-1:0] filtered;
        logic                       frame_end;
    } conv_sum_t;

    typedef enum bit {STEP_REG, STEP_PIX} step_kind_t;

    typedef struct {
        step_kind_t           kind;
        reg_idx_t             idx;
        logic [DATA_BITS-1:0] data;
        px_t                  px;
        bit                   typed;
        conv_sum_t            want;
    } dir_step_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [ADDR_BITS-1:0]          paddr;
    logic [DATA_BITS-1:0]          pwdata;
    logic [DATA_BITS-1:0]          prdata;
    logic                          pready;
    logic                          pixel_valid;
    logic                          pixel_ready;
    px_t                           pixel;
    logic                          result_valid;
    logic                          result_ready;
    logic signed [OUT_BITS-1:0]    filtered;
    logic                          frame_end;

    // shadow of the block
    logic [COEF_ROW_W-1:0] kern_row [KSIZE] = '{default: '0};
    logic [ROWS_BITS-1:0]  cfg_rows = ROWS_RESET;
    logic [COLS_BITS-1:0]  cfg_cols = COLS_RESET;
    px_t                   line_prev_px  [MAX_COLS];
    px_t                   line_prev2_px [MAX_COLS];
    px_t                   win_px [2*KSIZE];
    int unsigned           col_at = 0;
    int unsigned           row_at = 0;

    conv_sum_t   pending_sums [$];
    dir_step_t   dir_steps [$];
    reg_idx_t    coef_regs [KSIZE] = '{REG_COEF_ROW_0, REG_COEF_ROW_1, REG_COEF_ROW_2};

    bit          drv_typed;
    conv_sum_t   drv_want;
    bit          src_burst;
    bit          hold_req;
    int          sink_mode;
    int          err_cnt;
    int          pixels_in;
    int          results_seen;
    int          reg_writes;
    int          rand_frames;
    int          pauses;
    int          blocked_cycles;
    int          cycle_cnt;

    conv3x3_line_buffer_filter_unit #(
        .MAX_COLS   (MAX_COLS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .filtered     (filtered),
        .frame_end    (frame_end)
    );

    always #5 clk = ~clk;

    task automatic flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= 40)
        begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    function automatic bit conv_window_step(input px_t px, output conv_sum_t sum);
        int unsigned ncols;
        int unsigned nrows;
        int unsigned c;
        int unsigned r;
        px_t         above;
        px_t         above2;
        px_t         tap [KSIZE][KSIZE];
        px_t         k;
        longint      acc;
        bit          last_c;
        bit          last_r;
        ncols = (cfg_cols == 0) ? 1 : ((cfg_cols > MAX_COLS) ? MAX_COLS : cfg_cols);
        nrows = (cfg_rows == 0) ? 1 : cfg_rows;
        c = (col_at >= ncols) ? ncols - 1 : col_at;
        r = row_at;
        above  = line_prev_px[c];
        above2 = line_prev2_px[c];
        line_prev2_px[c] = above;
        line_prev_px[c]  = px;
        last_c = (c >= ncols - 1);
        last_r = (r >= nrows - 1);
        for (int a = 0; a < KSIZE; a++)
        begin
            tap[a][0] = win_px[a];
            tap[a][1] = win_px[a+KSIZE];
        end
        tap[0][2] = px;
        tap[1][2] = above;
        tap[2][2] = above2;
        acc = 0;
        for (int a = 0; a < KSIZE; a++)
        begin
            for (int b = 0; b < KSIZE; b++)
            begin
                k = kern_row[a][COEF_BITS*b +: COEF_BITS];
                acc += longint'(k) * longint'(tap[a][b]);
            end
        end
        sum.filtered  = acc[OUT_BITS-1:0];
        sum.frame_end = last_c && last_r;
        for (int a = 0; a < KSIZE; a++)
        begin
            win_px[a] = win_px[a+KSIZE];
        end
        win_px[3] = px;
        win_px[4] = above;
        win_px[5] = above2;
        if (last_c)
        begin
            col_at = 0;
            row_at = last_r ? 0 : ((r + 1) & 16'hFFFF);
        end
        else
        begin
            col_at = c + 1;
        end
        return (r >= KSIZE - 1) && (c >= KSIZE - 1);
    endfunction

    // beat monitor: checks outputs first, then steps the shadow on input beats
    always @(posedge clk)
    begin
        conv_sum_t pred_sum;
        conv_sum_t exp_sum;
        if (rst_n)
        begin
            if (pixel_valid && !pixel_ready)
            begin
                blocked_cycles++;
            end
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (pending_sums.size() == 0)
                begin
                    flag_error($sformatf("result beat with none pending: filtered=%0d end=%0b",
                                         filtered, frame_end));
                end
                else
                begin
                    exp_sum = pending_sums.pop_front();
                    if (filtered !== exp_sum.filtered)
                    begin
                        flag_error($sformatf("filtered got %0d want %0d",
                                             filtered, exp_sum.filtered));
                    end
                    if (frame_end !== exp_sum.frame_end)
                    begin
                        flag_error($sformatf("frame_end got %0b want %0b",
                                             frame_end, exp_sum.frame_end));
                    end
                end
            end
            if (pixel_valid && pixel_ready)
            begin
                pixels_in++;
                if (conv_window_step(pixel, pred_sum))
                begin
                    pending_sums.push_back(drv_typed ? drv_want : pred_sum);
                end
            end
        end
    end

    // result sink with random stalls and a requested long hold
    initial
    begin
        int stall_left;
        int hold_cnt;
        int r;
        result_ready = 1'b0;
        stall_left = 0;
        sink_mode = 1;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_ready <= 1'b0;
                hold_cnt = 0;
                while (hold_cnt < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    hold_cnt++;
                end
            end
            else if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ready <= 1'b1;
                if ($urandom_range(0, 199) == 0)
                begin
                    sink_mode = $urandom_range(0, 2);
                end
                r = $urandom_range(0, 99);
                if (sink_mode == 0 || r < 60 - 20 * sink_mode)
                    stall_left = 0;
                else if (r < 90)
                    stall_left = $urandom_range(1, 3);
                else if (r < 98)
                    stall_left = $urandom_range(4, 10);
                else
                    stall_left = $urandom_range(20, 60);
            end
        end
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d sums still pending",
                 cycle_cnt, pending_sums.size());
        $display("== FAIL ==");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (src_burst)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic px_t pick_pixel();
        case ($urandom_range(0, 15))
            0: return px_t'(16'h8000);
            1: return px_t'(16'h7FFF);
            2: return '0;
            3: return '1;
            default: return px_t'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input px_t v, input bit typed, input conv_sum_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= v;
        drv_typed   <= typed;
        drv_want    <= want;
        do @(posedge clk); while (!pixel_ready);
    endtask

    task automatic drain_results();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (pending_sums.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic stream_pixels(input int count, input bit may_pause);
        conv_sum_t blank;
        blank.filtered  = '0;
        blank.frame_end = 1'b0;
        for (int n = 0; n < count; n++)
        begin
            send_pixel(pick_pixel(), 1'b0, blank);
            if (may_pause && $urandom_range(0, 79) == 0)
            begin
                drain_results();
                pauses++;
            end
        end
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [DATA_BITS-1:0] val);
        int                   width;
        logic [DATA_BITS-1:0] rd_want;
        case (idx)
            REG_COEF_ROW_0, REG_COEF_ROW_1, REG_COEF_ROW_2: width = COEF_ROW_W;
            REG_FRAME_ROWS: width = ROWS_BITS;
            REG_FRAME_COLS: width = COLS_BITS;
            default: width = 0;
        endcase
        rd_want = val & ((64'd1 << width) - 64'd1);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, {REG_SHIFT{1'b0}}};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_COEF_ROW_0: kern_row[0] = rd_want[COEF_ROW_W-1:0];
            REG_COEF_ROW_1: kern_row[1] = rd_want[COEF_ROW_W-1:0];
            REG_COEF_ROW_2: kern_row[2] = rd_want[COEF_ROW_W-1:0];
            REG_FRAME_ROWS: cfg_rows = rd_want[ROWS_BITS-1:0];
            REG_FRAME_COLS: cfg_cols = rd_want[COLS_BITS-1:0];
            default: ;
        endcase
        reg_writes++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== rd_want)
        begin
            flag_error($sformatf("register %0d reads %0h want %0h", idx, prdata, rd_want));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic tbl_reg(input reg_idx_t idx, input logic [DATA_BITS-1:0] data);
        dir_step_t s;
        s.kind  = STEP_REG;
        s.idx   = idx;
        s.data  = data;
        s.px    = '0;
        s.typed = 1'b0;
        s.want.filtered  = '0;
        s.want.frame_end = 1'b0;
        dir_steps.push_back(s);
    endtask

    task automatic tbl_pix(input px_t px, input bit typed,
                           input logic signed [OUT_BITS-1:0] want, input bit want_end);
        dir_step_t s;
        s.kind  = STEP_PIX;
        s.idx   = REG_COEF_ROW_0;
        s.data  = '0;
        s.px    = px;
        s.typed = typed;
        s.want.filtered  = want;
        s.want.frame_end = want_end;
        dir_steps.push_back(s);
    endtask

    initial
    begin
        logic [DATA_BITS-1:0] kv;
        int                   nrows;
        int                   ncols;
        int                   sel;
        int                   rand_pixels;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        pixel_valid = 1'b0;
        pixel       = '0;
        drv_typed   = 1'b0;
        drv_want.filtered  = '0;
        drv_want.frame_end = 1'b0;
        src_burst   = 1'b0;
        hold_req    = 1'b0;
        rand_pixels = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x3 frame on reset coefficients: sum is zero
        tbl_reg(REG_FRAME_ROWS, 64'd3);
        tbl_reg(REG_FRAME_COLS, 64'd3);
        tbl_pix(16'h8000, 1'b0, '0, 1'b0);
        tbl_pix(16'h7FFF, 1'b0, '0, 1'b0);
        tbl_pix(16'h0000, 1'b0, '0, 1'b0);
        tbl_pix(16'hFFFF, 1'b0, '0, 1'b0);
        tbl_pix(16'h0001, 1'b0, '0, 1'b0);
        tbl_pix(16'h8000, 1'b0, '0, 1'b0);
        tbl_pix(16'h7FFF, 1'b0, '0, 1'b0);
        tbl_pix(16'h5555, 1'b0, '0, 1'b0);
        tbl_pix(16'hAAAA, 1'b1, '0, 1'b1);
        // most negative kernel times most negative pixels: 9 * 2^30
        tbl_reg(REG_COEF_ROW_0, {16'h0, {3{16'h8000}}});
        tbl_reg(REG_COEF_ROW_1, {16'h0, {3{16'h8000}}});
        tbl_reg(REG_COEF_ROW_2, {16'h0, {3{16'h8000}}});
        for (int i = 0; i < 8; i++)
        begin
            tbl_pix(16'h8000, 1'b0, '0, 1'b0);
        end
        tbl_pix(16'h8000, 1'b1, 36'sh240000000, 1'b1);
        // zero rows and columns act as one: each pixel is a 1x1 frame
        tbl_reg(REG_COEF_ROW_0, {16'h0, 16'h7FFF, 16'h0100, 16'hFF00});
        tbl_reg(REG_FRAME_COLS, 64'd0);
        tbl_reg(REG_FRAME_ROWS, 64'd0);
        tbl_pix(16'h7FFF, 1'b0, '0, 1'b0);
        tbl_pix(16'h8000, 1'b0, '0, 1'b0);

        foreach (dir_steps[i])
        begin
            if (dir_steps[i].kind == STEP_REG)
            begin
                drain_results();
                reg_write(dir_steps[i].idx, dir_steps[i].data);
            end
            else
            begin
                send_pixel(dir_steps[i].px, dir_steps[i].typed, dir_steps[i].want);
            end
        end

        // tallest frame setting, cut short by lowering the row count mid frame
        drain_results();
        reg_write(REG_COEF_ROW_1, {16'h0, 16'h8000, 16'h7FFF, 16'h0001});
        reg_write(REG_COEF_ROW_2, {16'h0, 16'h1234, 16'hFEDC, 16'h0100});
        reg_write(REG_FRAME_COLS, 64'd3);
        reg_write(REG_FRAME_ROWS, 64'd65535);
        stream_pixels(15, 1'b0);
        drain_results();
        reg_write(REG_FRAME_ROWS, 64'd4);
        stream_pixels(3, 1'b0);

        // column count lowered below the current position mid frame
        drain_results();
        reg_write(REG_FRAME_ROWS, 64'd6);
        reg_write(REG_FRAME_COLS, 64'd8);
        stream_pixels(29, 1'b0);
        drain_results();
        reg_write(REG_FRAME_COLS, 64'd4);
        stream_pixels(9, 1'b0);

        // long output hold while the sender keeps offering beats
        drain_results();
        reg_write(REG_FRAME_COLS, 64'd6);
        src_burst = 1'b1;
        hold_req  = 1'b1;
        stream_pixels(36, 1'b0);

        while (rand_pixels < RAND_ITEMS)
        begin
            drain_results();
            foreach (coef_regs[i])
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    case ($urandom_range(0, 5))
                        0: kv = {16'h0, {3{16'h8000}}};
                        1: kv = {16'h0, {3{16'h7FFF}}};
                        2: kv = {16'h0, {3{16'h0100}}};
                        default: kv = {$urandom, $urandom};
                    endcase
                    reg_write(coef_regs[i], {16'h0, kv[COEF_ROW_W-1:0]});
                end
            end
            sel = $urandom_range(0, 99);
            if (sel < 80)
            begin
                nrows = $urandom_range(3, 7);
                ncols = $urandom_range(3, 10);
            end
            else if (sel < 90)
            begin
                nrows = $urandom_range(0, 2);
                ncols = $urandom_range(0, 12);
            end
            else if (sel < 95)
            begin
                nrows = $urandom_range(3, 6);
                ncols = $urandom_range(0, 2);
            end
            else
            begin
                nrows = $urandom_range(3, 4);
                ncols = $urandom_range(11, 40);
            end
            reg_write(REG_FRAME_ROWS, 64'(nrows));
            reg_write(REG_FRAME_COLS, 64'(ncols));
            nrows = (nrows == 0) ? 1 : nrows;
            ncols = (ncols == 0) ? 1 : ncols;
            src_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 24) == 0)
            begin
                hold_req = 1'b1;
            end
            stream_pixels(nrows * ncols, 1'b1);
            rand_pixels += nrows * ncols;
            rand_frames++;
        end

        drain_results();
        if (pending_sums.size() != 0)
        begin
            flag_error($sformatf("%0d sums never came out", pending_sums.size()));
        end
        $display("covered %0d pixels, %0d result beats, %0d register writes, %0d random frames",
                 pixels_in, results_seen, reg_writes, rand_frames);
        $display("input blocked by output stalls on %0d cycles, %0d mid-frame drains",
                 blocked_cycles, pauses);
        if (err_cnt == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
